FILE: rtl/core/look_at_view_matrix_core_macros.svh
// assertion macros for the view matrix core
`ifndef LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH
`define LOOK_AT_VIEW_MATRIX_CORE_MACROS_SVH

// same-cycle implication
`define LAV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define LAV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: rtl/core/lav_pkg.sv
package lav_pkg;

	localparam int COORD_WIDTH    = 32;
	localparam int UNIT_FRAC_BITS = 30;
	localparam int AXIS_WIDTH     = UNIT_FRAC_BITS + 2;
	localparam int TRANS_WIDTH    = 34;
	localparam int DIFF_WIDTH     = COORD_WIDTH + 1;
	localparam int PROD_WIDTH     = COORD_WIDTH + DIFF_WIDTH;
	localparam int NORM_WIDTH     = PROD_WIDTH + 1;
	localparam int NORM_SHIFTS    = $clog2(NORM_WIDTH);
	localparam int NORM_BITS      = 31;
	localparam int SQRT_STEPS     = NORM_BITS + 1;
	localparam int DIV_STEPS      = UNIT_FRAC_BITS + 1;
	localparam int NORM_LATENCY   = 4 + NORM_SHIFTS + SQRT_STEPS + DIV_STEPS;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_EYE      = 2'd1;
	localparam logic [1:0] STATUS_PARALLEL = 2'd2;

	localparam logic [1:0] ROW_RIGHT   = 2'd0;
	localparam logic [1:0] ROW_UP      = 2'd1;
	localparam logic [1:0] ROW_FORWARD = 2'd2;

	typedef logic [2:0][AXIS_WIDTH-1:0] vec_t;

	typedef struct packed {
		logic vld;
		logic nz;
	} norm_flags_t;

endpackage

FILE: rtl/core/lav_norm.sv
module lav_norm (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_vld,
	input  logic [2:0][lav_pkg::NORM_WIDTH-1:0]    in_mag,
	input  logic [2:0]                             in_neg,
	output lav_pkg::norm_flags_t                   out_flags,
	output lav_pkg::vec_t                          out_axis
);

	localparam int NW  = lav_pkg::NORM_WIDTH;
	localparam int NSH = lav_pkg::NORM_SHIFTS;
	localparam int NB  = lav_pkg::NORM_BITS;
	localparam int SQ  = lav_pkg::SQRT_STEPS;
	localparam int DV  = lav_pkg::DIV_STEPS;
	localparam int LAT = lav_pkg::NORM_LATENCY;
	localparam int AXW = lav_pkg::AXIS_WIDTH;
	localparam int SW  = 2 * NB + 2;
	localparam int LW  = NB + 1;
	localparam int RW  = LW + 1;
	localparam int QW  = lav_pkg::UNIT_FRAC_BITS + 1;

	logic [LAT-1:0] vld_q;

	logic [2:0][NW-1:0] sh_m_s   [NSH+1];
	logic [2:0]         sh_neg_s [NSH+1];
	logic               sh_nz_s  [NSH+1];

	logic [2:0][2*NB-1:0] sq_p_s;
	logic [2:0][NB-1:0]   sq_n_s;
	logic [2:0]           sq_neg_s;
	logic                 sq_nz_s;

	logic [SW-1:0]      rt_rem_s [SQ+1];
	logic [SW-1:0]      rt_res_s [SQ+1];
	logic [2:0][NB-1:0] rt_n_s   [SQ+1];
	logic [2:0]         rt_neg_s [SQ+1];
	logic               rt_nz_s  [SQ+1];

	logic [2:0][RW-1:0] dv_r_s   [DV];
	logic [2:0][QW-1:0] dv_q_s   [DV];
	logic [LW-1:0]      dv_len_s [DV];
	logic [2:0]         dv_neg_s [DV];
	logic               dv_nz_s  [DV];

	logic nz_o_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], in_vld};
		end
	end

	always_ff @(posedge clk) begin
		sh_m_s[0]   <= in_mag;
		sh_neg_s[0] <= in_neg;
		sh_nz_s[0]  <= |(in_mag[0] | in_mag[1] | in_mag[2]);
	end

	// leading-one alignment, one shift weight per stage
	for (genvar k = 0; k < NSH; k++) begin : g_shift
		localparam int SH = 1 << (NSH - 1 - k);
		logic [NW-1:0] or_w;
		assign or_w = sh_m_s[k][0] | sh_m_s[k][1] | sh_m_s[k][2];
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (or_w[NW-1 -: SH] == '0) begin
					sh_m_s[k+1][i] <= sh_m_s[k][i] << SH;
				end else begin
					sh_m_s[k+1][i] <= sh_m_s[k][i];
				end
			end
			sh_neg_s[k+1] <= sh_neg_s[k];
			sh_nz_s[k+1]  <= sh_nz_s[k];
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_n_s[i] <= sh_m_s[NSH][i][NW-1 -: NB];
			sq_p_s[i] <= (2*NB)'(sh_m_s[NSH][i][NW-1 -: NB]) *
				(2*NB)'(sh_m_s[NSH][i][NW-1 -: NB]);
		end
		sq_neg_s <= sh_neg_s[NSH];
		sq_nz_s  <= sh_nz_s[NSH];
	end

	always_ff @(posedge clk) begin
		rt_rem_s[0] <= SW'(sq_p_s[0]) + SW'(sq_p_s[1]) + SW'(sq_p_s[2]);
		rt_res_s[0] <= '0;
		rt_n_s[0]   <= sq_n_s;
		rt_neg_s[0] <= sq_neg_s;
		rt_nz_s[0]  <= sq_nz_s;
	end

	// integer square root, one result bit per stage
	for (genvar j = 0; j < SQ; j++) begin : g_sqrt
		localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2 * j);
		logic [SW-1:0] trial_w;
		assign trial_w = rt_res_s[j] + BIT;
		always_ff @(posedge clk) begin
			if (rt_rem_s[j] >= trial_w) begin
				rt_rem_s[j+1] <= rt_rem_s[j] - trial_w;
				rt_res_s[j+1] <= (rt_res_s[j] >> 1) + BIT;
			end else begin
				rt_rem_s[j+1] <= rt_rem_s[j];
				rt_res_s[j+1] <= rt_res_s[j] >> 1;
			end
			rt_n_s[j+1]   <= rt_n_s[j];
			rt_neg_s[j+1] <= rt_neg_s[j];
			rt_nz_s[j+1]  <= rt_nz_s[j];
		end
	end

	// restoring divide of each component by the length
	for (genvar k = 0; k < DV; k++) begin : g_div
		logic [2:0][RW-1:0] t_w;
		logic [2:0][QW-1:0] qi_w;
		logic [LW-1:0]      len_w;
		logic [2:0]         neg_w;
		logic               nz_w;
		if (k == 0) begin : g_first
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					t_w[i] = RW'(rt_n_s[SQ][i]);
				end
				qi_w  = '0;
				len_w = rt_res_s[SQ][LW-1:0];
				neg_w = rt_neg_s[SQ];
				nz_w  = rt_nz_s[SQ];
			end
		end else begin : g_next
			always_comb begin
				for (int i = 0; i < 3; i++) begin
					t_w[i] = {dv_r_s[k-1][i][RW-2:0], 1'b0};
				end
				qi_w  = dv_q_s[k-1];
				len_w = dv_len_s[k-1];
				neg_w = dv_neg_s[k-1];
				nz_w  = dv_nz_s[k-1];
			end
		end
		always_ff @(posedge clk) begin
			for (int i = 0; i < 3; i++) begin
				if (t_w[i] >= RW'(len_w)) begin
					dv_r_s[k][i] <= t_w[i] - RW'(len_w);
					dv_q_s[k][i] <= {qi_w[i][QW-2:0], 1'b1};
				end else begin
					dv_r_s[k][i] <= t_w[i];
					dv_q_s[k][i] <= {qi_w[i][QW-2:0], 1'b0};
				end
			end
			dv_len_s[k] <= len_w;
			dv_neg_s[k] <= neg_w;
			dv_nz_s[k]  <= nz_w;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (!dv_nz_s[DV-1]) begin
				out_axis[i] <= '0;
			end else if (dv_neg_s[DV-1][i]) begin
				out_axis[i] <= ~AXW'(dv_q_s[DV-1][i]) + AXW'(1);
			end else begin
				out_axis[i] <= AXW'(dv_q_s[DV-1][i]);
			end
		end
		nz_o_q <= dv_nz_s[DV-1];
	end

	assign out_flags = '{vld: vld_q[LAT-1], nz: nz_o_q};

endmodule

FILE: rtl/core/look_at_view_matrix_core.sv
// channel   direction  handshake            payload
// command   in         start, busy          eye_*, target_*, up_*
// result    out        valid (strobe)       row_index, axis_*, translation, status, last
//
// one command gives three result rows on consecutive cycles
// a command is taken when start is high and busy is low; busy is raised after each transfer
// the first row follows the transfer through the normalizer pipeline (alignment, square
// root and divide stages, one bit per root or divide stage) plus the cross and dot stages
// arst_n clears all valid bits, the row counter and busy; no clearing pass
// the result side cannot stall; rows leave as the strobe shows them
module look_at_view_matrix_core (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       start,
	output logic                                       busy,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     eye_x,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     eye_y,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     eye_z,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     target_x,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     target_y,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     target_z,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     up_x,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     up_y,
	input  logic signed [lav_pkg::COORD_WIDTH-1:0]     up_z,
	output logic                                       valid,
	output logic [1:0]                                 row_index,
	output logic signed [lav_pkg::AXIS_WIDTH-1:0]      axis_x,
	output logic signed [lav_pkg::AXIS_WIDTH-1:0]      axis_y,
	output logic signed [lav_pkg::AXIS_WIDTH-1:0]      axis_z,
	output logic signed [lav_pkg::TRANS_WIDTH-1:0]     translation,
	output logic [1:0]                                 status,
	output logic                                       last
);

	localparam int CW  = lav_pkg::COORD_WIDTH;
	localparam int DW  = lav_pkg::DIFF_WIDTH;
	localparam int PW  = lav_pkg::PROD_WIDTH;
	localparam int XW  = lav_pkg::NORM_WIDTH;
	localparam int AXW = lav_pkg::AXIS_WIDTH;
	localparam int UFB = lav_pkg::UNIT_FRAC_BITS;
	localparam int TRW = lav_pkg::TRANS_WIDTH;
	localparam int LAT = lav_pkg::NORM_LATENCY;
	localparam int PRW = 2 * AXW;
	localparam int UMW = PRW - UFB;
	localparam int TPW = AXW + CW;
	localparam int TSW = TPW + 2;
	localparam int MW  = TSW - UFB;

	localparam logic [UMW-1:0] UNIT_ONE = UMW'(1) << UFB;
	localparam logic [MW-1:0]  LIM_NEG  = MW'(1) << (TRW - 1);
	localparam logic [MW-1:0]  LIM_POS  = LIM_NEG - MW'(1);

	logic       accept;
	logic [1:0] busy_cnt_q;

	logic                v_s1, v_s2, v_s3, v_s4;
	logic [2:0][CW-1:0]  eye_s1, tgt_s1, up_s1;
	logic [2:0][CW-1:0]  eye_s2, up_s2;
	logic [2:0][DW-1:0]  d_s2, d_s3, d_s4;
	logic [2:0][CW-1:0]  eye_s3, eye_s4;
	logic [5:0][PW-1:0]  p_s3;
	logic [2:0][XW-1:0]  c_s4;

	logic [2:0][XW-1:0]  fmag_w, rmag_w;
	logic [2:0]          fneg_w, rneg_w;
	logic [2:0][DW-1:0]  dabs_w;

	lav_pkg::norm_flags_t fwd_flags, rgt_flags;
	lav_pkg::vec_t        fwd_axis, rgt_axis;

	logic [2:0][CW-1:0]  eye_dl_q [LAT];

	logic                v_u1, v_u2, v_u3, v_u4, v_u5, v_u6, v_u7;
	logic [5:0][PRW-1:0] fr_u1;
	logic [2:0][PRW-1:0] uc_u2;
	lav_pkg::vec_t       f_u1, r_u1, f_u2, r_u2;
	lav_pkg::vec_t       up_w;
	logic [2:0][CW-1:0]  eye_u1, eye_u2, eye_u3;
	logic [1:0]          st_u1, st_u2, st_u3, st_u4, st_u5, st_u6, st_u7;
	lav_pkg::vec_t [2:0] ax_u3, ax_u4, ax_u5, ax_u6, ax_u7;
	logic [8:0][TPW-1:0] tp_u4;
	logic [2:0][TSW-1:0] sum_u5;
	logic [2:0][MW-1:0]  m_u6;
	logic [2:0]          negr_u6;
	logic [2:0][TRW-1:0] tr_u7;

	logic                 valid_q, last_q;
	logic [1:0]           row_q, status_q, cnt_q;
	lav_pkg::vec_t        axis_q;
	logic [TRW-1:0]       trans_q;
	lav_pkg::vec_t [2:1]  hold_ax_q;
	logic [2:1][TRW-1:0]  hold_tr_q;

	assign accept = start && !busy;
	assign busy   = (busy_cnt_q != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_cnt_q <= 2'd0;
		end else if (accept) begin
			busy_cnt_q <= 2'd2;
		end else if (busy_cnt_q != 2'd0) begin
			busy_cnt_q <= busy_cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_u1 <= 1'b0;
			v_u2 <= 1'b0;
			v_u3 <= 1'b0;
			v_u4 <= 1'b0;
			v_u5 <= 1'b0;
			v_u6 <= 1'b0;
			v_u7 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_u1 <= fwd_flags.vld;
			v_u2 <= v_u1;
			v_u3 <= v_u2;
			v_u4 <= v_u3;
			v_u5 <= v_u4;
			v_u6 <= v_u5;
			v_u7 <= v_u6;
		end
	end

	always_ff @(posedge clk) begin
		eye_s1 <= {eye_z, eye_y, eye_x};
		tgt_s1 <= {target_z, target_y, target_x};
		up_s1  <= {up_z, up_y, up_x};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			d_s2[i] <= DW'($signed(eye_s1[i])) - DW'($signed(tgt_s1[i]));
		end
		eye_s2 <= eye_s1;
		up_s2  <= up_s1;
	end

	// up hint cross (eye - target)
	always_ff @(posedge clk) begin
		p_s3[0] <= PW'($signed(up_s2[1])) * PW'($signed(d_s2[2]));
		p_s3[1] <= PW'($signed(up_s2[2])) * PW'($signed(d_s2[1]));
		p_s3[2] <= PW'($signed(up_s2[2])) * PW'($signed(d_s2[0]));
		p_s3[3] <= PW'($signed(up_s2[0])) * PW'($signed(d_s2[2]));
		p_s3[4] <= PW'($signed(up_s2[0])) * PW'($signed(d_s2[1]));
		p_s3[5] <= PW'($signed(up_s2[1])) * PW'($signed(d_s2[0]));
		d_s3    <= d_s2;
		eye_s3  <= eye_s2;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			c_s4[i] <= XW'($signed(p_s3[2*i])) - XW'($signed(p_s3[2*i+1]));
		end
		d_s4   <= d_s3;
		eye_s4 <= eye_s3;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fneg_w[i] = d_s4[i][DW-1];
			dabs_w[i] = fneg_w[i] ? (~d_s4[i] + DW'(1)) : d_s4[i];
			fmag_w[i] = XW'(dabs_w[i]);
			rneg_w[i] = c_s4[i][XW-1];
			rmag_w[i] = rneg_w[i] ? (~c_s4[i] + XW'(1)) : c_s4[i];
		end
	end

	lav_norm u_norm_fwd (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (v_s4),
		.in_mag    (fmag_w),
		.in_neg    (fneg_w),
		.out_flags (fwd_flags),
		.out_axis  (fwd_axis)
	);

	lav_norm u_norm_rgt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (v_s4),
		.in_mag    (rmag_w),
		.in_neg    (rneg_w),
		.out_flags (rgt_flags),
		.out_axis  (rgt_axis)
	);

	always_ff @(posedge clk) begin
		eye_dl_q[0] <= eye_s4;
	end

	for (genvar k = 1; k < LAT; k++) begin : g_eye_dl
		always_ff @(posedge clk) begin
			eye_dl_q[k] <= eye_dl_q[k-1];
		end
	end

	// forward cross right
	always_ff @(posedge clk) begin
		fr_u1[0] <= PRW'($signed(fwd_axis[1])) * PRW'($signed(rgt_axis[2]));
		fr_u1[1] <= PRW'($signed(fwd_axis[2])) * PRW'($signed(rgt_axis[1]));
		fr_u1[2] <= PRW'($signed(fwd_axis[2])) * PRW'($signed(rgt_axis[0]));
		fr_u1[3] <= PRW'($signed(fwd_axis[0])) * PRW'($signed(rgt_axis[2]));
		fr_u1[4] <= PRW'($signed(fwd_axis[0])) * PRW'($signed(rgt_axis[1]));
		fr_u1[5] <= PRW'($signed(fwd_axis[1])) * PRW'($signed(rgt_axis[0]));
		f_u1     <= fwd_axis;
		r_u1     <= rgt_axis;
		eye_u1   <= eye_dl_q[LAT-1];
		st_u1    <= !fwd_flags.nz ? lav_pkg::STATUS_EYE :
			(!rgt_flags.nz ? lav_pkg::STATUS_PARALLEL : lav_pkg::STATUS_OK);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			uc_u2[i] <= fr_u1[2*i] - fr_u1[2*i+1];
		end
		f_u2   <= f_u1;
		r_u2   <= r_u1;
		eye_u2 <= eye_u1;
		st_u2  <= st_u1;
	end

	// truncate toward zero and clamp to one
	always_comb begin
		logic [PRW-1:0] mag;
		logic [UMW-1:0] m;
		logic [AXW-1:0] cl;
		for (int i = 0; i < 3; i++) begin
			mag = uc_u2[i][PRW-1] ? (~uc_u2[i] + PRW'(1)) : uc_u2[i];
			m   = mag[PRW-1:UFB];
			cl  = (m > UNIT_ONE) ? AXW'(UNIT_ONE) : AXW'(m);
			up_w[i] = uc_u2[i][PRW-1] ? (~cl + AXW'(1)) : cl;
		end
	end

	always_ff @(posedge clk) begin
		ax_u3[lav_pkg::ROW_RIGHT]   <= r_u2;
		ax_u3[lav_pkg::ROW_UP]      <= up_w;
		ax_u3[lav_pkg::ROW_FORWARD] <= f_u2;
		eye_u3 <= eye_u2;
		st_u3  <= st_u2;
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int i = 0; i < 3; i++) begin
				tp_u4[3*r+i] <= TPW'($signed(ax_u3[r][i])) * TPW'($signed(eye_u3[i]));
			end
		end
		ax_u4 <= ax_u3;
		st_u4 <= st_u3;
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_u5[r] <= TSW'($signed(tp_u4[3*r])) + TSW'($signed(tp_u4[3*r+1])) +
				TSW'($signed(tp_u4[3*r+2]));
		end
		ax_u5 <= ax_u4;
		st_u5 <= st_u4;
	end

	always_ff @(posedge clk) begin
		logic [TSW-1:0] mag;
		for (int r = 0; r < 3; r++) begin
			mag        = sum_u5[r][TSW-1] ? (~sum_u5[r] + TSW'(1)) : sum_u5[r];
			m_u6[r]    <= mag[TSW-1:UFB];
			negr_u6[r] <= !sum_u5[r][TSW-1];
		end
		ax_u6 <= ax_u5;
		st_u6 <= st_u5;
	end

	// saturate and negate
	always_ff @(posedge clk) begin
		logic [MW-1:0] lim;
		logic [MW-1:0] v;
		for (int r = 0; r < 3; r++) begin
			lim = negr_u6[r] ? LIM_NEG : LIM_POS;
			v   = (m_u6[r] > lim) ? lim : m_u6[r];
			tr_u7[r] <= negr_u6[r] ? (~TRW'(v) + TRW'(1)) : TRW'(v);
		end
		ax_u7 <= ax_u6;
		st_u7 <= st_u6;
	end

	// row serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= 2'd0;
		end else if (v_u7) begin
			valid_q <= 1'b1;
			cnt_q   <= 2'd2;
		end else if (cnt_q != 2'd0) begin
			valid_q <= 1'b1;
			cnt_q   <= cnt_q - 2'd1;
		end else begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (v_u7) begin
			row_q     <= lav_pkg::ROW_RIGHT;
			axis_q    <= ax_u7[lav_pkg::ROW_RIGHT];
			trans_q   <= tr_u7[lav_pkg::ROW_RIGHT];
			status_q  <= st_u7;
			last_q    <= 1'b0;
			hold_ax_q <= {ax_u7[lav_pkg::ROW_FORWARD], ax_u7[lav_pkg::ROW_UP]};
			hold_tr_q <= {tr_u7[lav_pkg::ROW_FORWARD], tr_u7[lav_pkg::ROW_UP]};
		end else if (cnt_q == 2'd2) begin
			row_q   <= lav_pkg::ROW_UP;
			axis_q  <= hold_ax_q[1];
			trans_q <= hold_tr_q[1];
			last_q  <= 1'b0;
		end else if (cnt_q == 2'd1) begin
			row_q   <= lav_pkg::ROW_FORWARD;
			axis_q  <= hold_ax_q[2];
			trans_q <= hold_tr_q[2];
			last_q  <= 1'b1;
		end
	end

	assign valid       = valid_q;
	assign row_index   = row_q;
	assign axis_x      = axis_q[0];
	assign axis_y      = axis_q[1];
	assign axis_z      = axis_q[2];
	assign translation = trans_q;
	assign status      = status_q;
	assign last        = last_q;

`include "look_at_view_matrix_core_macros.svh"

	`LAV_ASSERT_NOW(a_norm_aligned, fwd_flags.vld || rgt_flags.vld,
		fwd_flags.vld && rgt_flags.vld, "normalizer outputs out of step")
	`LAV_ASSERT_NEXT(a_busy_after_transfer, accept, busy, "busy not raised after transfer")
	`LAV_ASSERT_NEXT(a_rows_burst, valid_q && !last_q, valid_q, "row burst broken")
	`LAV_ASSERT_NOW(a_serializer_free, v_u7, cnt_q == 2'd0, "result overran serializer")
	`LAV_ASSERT_NOW(a_eye_rows_zero, valid_q && status_q == lav_pkg::STATUS_EYE,
		axis_q == '0 && trans_q == '0, "nonzero row for eye equal target")

endmodule
